// ===== sv/wps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wps_pkg: shared types and constants for the windowed pattern search
// Field widths, configuration register codes, the configuration bundle,
// the match request passed from front to back, and the case fold helper.
// ----------------------------------------------------------------------------
package wps_pkg;

  // fixed field widths
  localparam int POS_W   = 20;
  localparam int COUNT_W = POS_W + 1;
  localparam int LEN_W   = 5;
  localparam int WORD_W  = 64;
  localparam int IDX_W   = 3;

  // text positions at or past this limit are not searched
  localparam logic [COUNT_W-1:0] MAX_TEXT = COUNT_W'(1048576);

  // configuration register codes
  typedef enum logic [IDX_W-1:0] {
    CFG_PAT_LO  = 3'd0,
    CFG_PAT_HI  = 3'd1,
    CFG_LENGTH  = 3'd2,
    CFG_FOLD    = 3'd3,
    CFG_FORWARD = 3'd4,
    CFG_START   = 3'd5
  } cfg_idx_t;

  // configuration bundle
  typedef struct packed {
    logic [WORD_W-1:0] pat_lo;
    logic [WORD_W-1:0] pat_hi;
    logic [LEN_W-1:0]  len;
    logic              fold;
    logic              forward;
    logic [POS_W-1:0]  start;
  } cfg_t;

  // per-byte request from front to back
  typedef struct packed {
    logic             qual;
    logic [POS_W-1:0] start;
    logic             last;
    logic             forward;
  } evt_t;

  // ascii upper case folded to lower case when enabled
  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
    logic [7:0] r;
    r = b;
    if (en && b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== sv/wps_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wps_front: byte window and parallel compare
// Shifts each accepted byte into the window, compares all lanes against the
// pattern at once and emits one qualified-match request per byte.
// ----------------------------------------------------------------------------
module wps_front #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  wps_pkg::cfg_t            cfg,
  input  logic                     take,
  input  logic [7:0]               text_byte,
  input  logic                     last_byte,
  output wps_pkg::evt_t            evt
);

  logic [7:0]                   window [MAX_PATTERN];
  logic [7:0]                   win_new [MAX_PATTERN];
  logic [wps_pkg::COUNT_W-1:0]  byte_count;
  logic [wps_pkg::COUNT_W-1:0]  count_inc;
  logic [MAX_PATTERN-1:0]       lane_ok;
  logic [wps_pkg::LEN_W-1:0]    pat_idx [MAX_PATTERN];
  logic [2*wps_pkg::WORD_W-1:0] pat_all;
  logic                         count_ok;
  logic                         len_ok;
  logic                         fill_ok;
  logic                         all_match;
  logic                         dir_ok;
  logic [wps_pkg::POS_W-1:0]    st;

  // window as it stands once this byte is in
  always_comb begin
    win_new[0] = text_byte;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win_new[i] = window[i-1];
    end
  end

  // lane compare: newest byte lines up with the last pattern byte
  assign pat_all = {cfg.pat_hi, cfg.pat_lo};
  always_comb begin
    for (int w = 0; w < MAX_PATTERN; w++) begin
      pat_idx[w] = cfg.len - wps_pkg::LEN_W'(1) - wps_pkg::LEN_W'(w);
      lane_ok[w] = (cfg.len <= wps_pkg::LEN_W'(w)) ||
                   (wps_pkg::fold_byte(win_new[w], cfg.fold) ==
                    wps_pkg::fold_byte(pat_all[pat_idx[w][3:0]*8 +: 8], cfg.fold));
    end
  end

  // qualification of the match that ends on this byte
  assign count_inc = byte_count + wps_pkg::COUNT_W'(1);
  assign count_ok  = byte_count < wps_pkg::MAX_TEXT;
  assign len_ok    = (cfg.len != '0) &&
                     (cfg.len <= wps_pkg::LEN_W'(MAX_PATTERN));
  assign fill_ok   = count_inc >= wps_pkg::COUNT_W'(cfg.len);
  assign all_match = &lane_ok;
  assign st        = wps_pkg::POS_W'(count_inc - wps_pkg::COUNT_W'(cfg.len));
  assign dir_ok    = cfg.forward ? (st > cfg.start) : (st < cfg.start);

  always_comb begin
    evt.qual    = count_ok && len_ok && fill_ok && all_match && dir_ok;
    evt.start   = st;
    evt.last    = last_byte;
    evt.forward = cfg.forward;
  end

  // byte counter, saturating, cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (take) begin
      if (last_byte) begin
        byte_count <= '0;
      end else if (count_ok) begin
        byte_count <= count_inc;
      end
    end
  end

  // window shift
  always_ff @(posedge clk) begin
    if (take && count_ok) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        window[i] <= win_new[i];
      end
    end
  end

endmodule

// ===== sv/wps_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wps_queue: short request queue between front and back
// Small register queue so the compare front and the result back stall apart.
// ----------------------------------------------------------------------------
module wps_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  wps_pkg::evt_t wr_data,
  output logic          full,
  input  logic          rd,
  output wps_pkg::evt_t rd_data,
  output logic          empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  wps_pkg::evt_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign rd_data = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr && !rd) begin
        count <= count + CNT_W'(1);
      end else if (rd && !wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/wps_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wps_back: match selection and result register
// Keeps the first (forward) or latest (backward) qualified match and loads
// the result register on the last byte of each text.
// ----------------------------------------------------------------------------
module wps_back (
  input  logic                      clk,
  input  logic                      rst,
  input  wps_pkg::evt_t             evt,
  input  logic                      evt_avail,
  output logic                      evt_take,
  output logic                      out_valid,
  input  logic                      out_take,
  output logic                      found,
  output logic [wps_pkg::POS_W-1:0] match_position
);

  logic                      have_match;
  logic [wps_pkg::POS_W-1:0] best_position;
  logic                      have_next;
  logic [wps_pkg::POS_W-1:0] best_next;

  // a last-byte request needs a free result slot
  assign evt_take = evt_avail && (!evt.last || !out_valid || out_take);

  // kept match update
  always_comb begin
    have_next = have_match;
    best_next = best_position;
    if (evt.qual && (!evt.forward || !have_match)) begin
      have_next = 1'b1;
      best_next = evt.start;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      have_match <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (evt_take) begin
        have_match <= evt.last ? 1'b0 : have_next;
      end
      if (evt_take && evt.last) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (evt_take) begin
      best_position <= evt.last ? '0 : best_next;
      if (evt.last) begin
        found          <= have_next;
        match_position <= have_next ? best_next : '0;
      end
    end
  end

endmodule

// ===== sv/windowed_pattern_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_pattern_search: streaming pattern search over a byte window
// Top level: configuration registers, compare front, request queue, back end.
// ----------------------------------------------------------------------------
// Takes one text byte per clock while full is low. Every byte is compared
// against the whole pattern at once by a row of parallel byte lanes, and
// the outcome goes into a four-entry request queue; the back end drains one
// request per cycle unless a last-byte request waits for the result slot,
// so the sustained rate is one byte per cycle. A result is held until
// popped; a waiting result only stalls the next last byte at the head of
// the queue, and three more bytes are taken behind it before full rises.
// Configuration goes through cfg_valid/cfg_ready (always ready); the user must
// write it only while no text is in flight; the block does not enforce it.
module windowed_pattern_search #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 text_byte,
  input  logic                       last_byte,
  output logic                       empty,
  input  logic                       pop,
  output logic                       found,
  output logic [wps_pkg::POS_W-1:0]  match_position,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [wps_pkg::IDX_W-1:0]  cfg_index,
  input  logic [wps_pkg::WORD_W-1:0] cfg_data
);

  wps_pkg::cfg_t cfg;
  wps_pkg::evt_t f_evt;
  wps_pkg::evt_t q_evt;
  logic          q_push;
  logic          q_pop;
  logic          q_empty;
  logic          out_valid;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pat_lo  <= '0;
      cfg.pat_hi  <= '0;
      cfg.len     <= '0;
      cfg.fold    <= 1'b1;
      cfg.forward <= 1'b1;
      cfg.start   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wps_pkg::CFG_PAT_LO:  cfg.pat_lo  <= cfg_data;
        wps_pkg::CFG_PAT_HI:  cfg.pat_hi  <= cfg_data;
        wps_pkg::CFG_LENGTH:  cfg.len     <= cfg_data[wps_pkg::LEN_W-1:0];
        wps_pkg::CFG_FOLD:    cfg.fold    <= cfg_data[0];
        wps_pkg::CFG_FORWARD: cfg.forward <= cfg_data[0];
        wps_pkg::CFG_START:   cfg.start   <= cfg_data[wps_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  // input request accepted
  assign q_push = push && !full;
  assign empty  = !out_valid;

  // compare front
  wps_front #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (q_push),
    .text_byte (text_byte),
    .last_byte (last_byte),
    .evt       (f_evt)
  );

  // request queue
  wps_queue #(
    .DEPTH(4)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (f_evt),
    .full    (full),
    .rd      (q_pop),
    .rd_data (q_evt),
    .empty   (q_empty)
  );

  // match selection and result
  wps_back u_back (
    .clk            (clk),
    .rst            (rst),
    .evt            (q_evt),
    .evt_avail      (!q_empty),
    .evt_take       (q_pop),
    .out_valid      (out_valid),
    .out_take       (pop && out_valid),
    .found          (found),
    .match_position (match_position)
  );

  // a result with no match carries position zero
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !found) |-> (match_position == '0))
    else $error("not-found result with nonzero position");

  // an accepted byte leaves the queue non-empty
  assert property (@(posedge clk) disable iff (rst)
    q_push |=> !q_empty)
    else $error("accepted request lost from queue");

  // a result only appears after a last-byte request was drained
  assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> $past(q_pop && q_evt.last))
    else $error("result appeared without a last-byte request");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for windowed_pattern_search
// Streams short texts through the queue-style byte port under several pattern
// settings and idle mixes. A scoreboard class keeps its own byte window and
// kept match, predicts the found flag and start index of every text, and
// compares each popped result against the oldest prediction.
// ----------------------------------------------------------------------------

localparam int PATTERN_SLOTS = 16;

// predicted outcome of one text
typedef struct {
  logic                      found;
  logic [wps_pkg::POS_W-1:0] position;
} search_outcome_t;

typedef logic [7:0] text_q_t[$];

class search_scoreboard;
  // register copy
  logic [wps_pkg::WORD_W-1:0] pat_lo;
  logic [wps_pkg::WORD_W-1:0] pat_hi;
  logic [wps_pkg::LEN_W-1:0]  pat_len;
  bit                         fold_on;
  bit                         forward_on;
  logic [wps_pkg::POS_W-1:0]  origin;
  // stream state
  logic [7:0]                 recent[PATTERN_SLOTS];
  int unsigned                taken;
  logic [wps_pkg::POS_W-1:0]  kept_pos;
  bit                         kept;
  // outcomes of texts whose last byte went in but whose result is not popped
  search_outcome_t            outcomes[$];
  int                         errors;

  function new();
    pat_lo     = '0;
    pat_hi     = '0;
    pat_len    = '0;
    fold_on    = 1'b1;
    forward_on = 1'b1;
    origin     = '0;
    errors     = 0;
    clear_text();
  endfunction

  function void clear_text();
    foreach (recent[i]) recent[i] = 8'h00;
    taken    = 0;
    kept_pos = '0;
    kept     = 1'b0;
  endfunction

  function logic [7:0] lower(logic [7:0] b);
    if (fold_on && b >= 8'h41 && b <= 8'h5A) return b + 8'h20;
    return b;
  endfunction

  function logic [7:0] pattern_at(int k);
    return (k < 8) ? pat_lo[8*k +: 8] : pat_hi[8*(k-8) +: 8];
  endfunction

  // newest pat_len bytes against the pattern, oldest byte first
  function bit window_hit();
    for (int k = 0; k < pat_len; k++) begin
      if (lower(recent[pat_len-1-k]) != lower(pattern_at(k))) return 1'b0;
    end
    return 1'b1;
  endfunction

  function void set_register(logic [wps_pkg::IDX_W-1:0] idx,
                             logic [wps_pkg::WORD_W-1:0] data);
    case (idx)
      wps_pkg::CFG_PAT_LO:  pat_lo = data;
      wps_pkg::CFG_PAT_HI:  pat_hi = data;
      wps_pkg::CFG_LENGTH:  pat_len = data[wps_pkg::LEN_W-1:0];
      wps_pkg::CFG_FOLD:    fold_on = data[0];
      wps_pkg::CFG_FORWARD: forward_on = data[0];
      wps_pkg::CFG_START:   origin = data[wps_pkg::POS_W-1:0];
      default:     ;
    endcase
  endfunction

  function void take_text_byte(logic [7:0] b, bit last);
    int unsigned pos;
    int unsigned st;
    search_outcome_t res;
    // bytes past the text limit are dropped
    if (taken < wps_pkg::MAX_TEXT) begin
      pos = taken;
      for (int i = PATTERN_SLOTS - 1; i > 0; i--) recent[i] = recent[i-1];
      recent[0] = b;
      taken++;
      if (pat_len >= 1 && pat_len <= PATTERN_SLOTS && pos + 1 >= pat_len &&
          window_hit()) begin
        st = pos + 1 - pat_len;
        if (forward_on) begin
          if (!kept && st > origin) begin
            kept     = 1'b1;
            kept_pos = st[wps_pkg::POS_W-1:0];
          end
        end else if (st < origin) begin
          kept     = 1'b1;
          kept_pos = st[wps_pkg::POS_W-1:0];
        end
      end
    end
    // one outcome per text
    if (last) begin
      res.found    = kept;
      res.position = kept ? kept_pos : '0;
      outcomes.insert(outcomes.size(), res);
      clear_text();
    end
  endfunction

  function void report(string what, longint want, longint got);
    errors++;
    if (errors <= 10) $display("%t: %s: expected %0d, got %0d", $realtime, what, want, got);
  endfunction

  function void compare_outcome(logic got_found, logic [wps_pkg::POS_W-1:0] got_pos);
    search_outcome_t want;
    if (outcomes.size() == 0) begin
      report("result with no text pending", 0, 1);
      return;
    end
    want = outcomes.pop_front();
    if (got_found !== want.found) report("found", want.found, got_found);
    if (got_pos !== want.position) report("match_position", want.position, got_pos);
  endfunction
endclass

module tb_top;

  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int PHASES          = 16;
  localparam int BYTES_PER_PHASE = 64;

  // index codes with no register behind them
  localparam logic [wps_pkg::IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [wps_pkg::IDX_W-1:0] CFG_SPARE_B = 3'd7;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       push = 1'b0;
  logic                       full;
  logic [7:0]                 text_byte = 8'h00;
  logic                       last_byte = 1'b0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic                       found;
  logic [wps_pkg::POS_W-1:0]  match_position;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [wps_pkg::IDX_W-1:0]  cfg_index = '0;
  logic [wps_pkg::WORD_W-1:0] cfg_data = '0;

  search_scoreboard sb = new();

  int         tx_idle_pct = 0;
  int         rx_stall_pct = 0;
  int         quiet_cycles = 0;
  logic [7:0] pat_bytes[PATTERN_SLOTS];
  int         pat_len = 0;

  windowed_pattern_search u_dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .text_byte      (text_byte),
    .last_byte      (last_byte),
    .empty          (empty),
    .pop            (pop),
    .found          (found),
    .match_position (match_position),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side: random stalls, check on every popped result
  always @(negedge clk) begin
    pop = ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.compare_outcome(found, match_position);
  end

  // watchdog on cycles with no request moving
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // all tasks start and end at a falling edge
  task automatic write_register(logic [wps_pkg::IDX_W-1:0] idx,
                                logic [wps_pkg::WORD_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.outcomes.size() != 0) @(negedge clk);
  endtask

  // settle, then write every register; narrow ones get junk upper bits
  task automatic program_search(logic [wps_pkg::WORD_W-1:0] lo,
                                logic [wps_pkg::WORD_W-1:0] hi,
                                logic [wps_pkg::LEN_W-1:0] len, bit fold, bit fwd,
                                logic [wps_pkg::POS_W-1:0] start);
    logic [wps_pkg::WORD_W-1:0] junk;
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    junk = {$urandom(), $urandom()};
    write_register(wps_pkg::CFG_PAT_LO, lo);
    write_register(wps_pkg::CFG_PAT_HI, hi);
    write_register(wps_pkg::CFG_LENGTH, {junk[wps_pkg::WORD_W-1:wps_pkg::LEN_W], len});
    write_register(wps_pkg::CFG_FOLD, {junk[wps_pkg::WORD_W-1:1], fold});
    write_register(wps_pkg::CFG_FORWARD, {~junk[wps_pkg::WORD_W-1:1], fwd});
    write_register(wps_pkg::CFG_START, {junk[wps_pkg::WORD_W-1:wps_pkg::POS_W], start});
    write_register($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, ~junk);
    for (int k = 0; k < PATTERN_SLOTS; k++) begin
      pat_bytes[k] = (k < 8) ? lo[8*k +: 8] : hi[8*(k-8) +: 8];
    end
    pat_len = len;
  endtask

  task automatic send_byte(logic [7:0] b, bit last);
    while ($urandom_range(99) < tx_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push      = 1'b1;
    text_byte = b;
    last_byte = last;
    do @(posedge clk); while (full);
    sb.take_text_byte(b, last);
    @(negedge clk);
    push = 1'b0;
  endtask

  task automatic send_text(text_q_t t);
    foreach (t[i]) send_byte(t[i], i == t.size() - 1);
  endtask

  function automatic text_q_t from_string(string s);
    text_q_t t;
    for (int i = 0; i < s.len(); i++) t.insert(t.size(), s[i]);
    return t;
  endfunction

  // small alphabet for frequent hits, plus the fold range boundaries
  function automatic logic [7:0] pick_byte();
    int r = $urandom_range(99);
    logic [7:0] letters[4] = '{8'h61, 8'h41, 8'h62, 8'h42};
    logic [7:0] edges[8] = '{8'h00, 8'hFF, 8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h7B};
    if (r < 65) return letters[$urandom_range(3)];
    if (r < 80) return edges[$urandom_range(7)];
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] flip_case(logic [7:0] b);
    if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) return b ^ 8'h20;
    return b;
  endfunction

  task automatic random_setup();
    logic [wps_pkg::WORD_W-1:0] lo;
    logic [wps_pkg::WORD_W-1:0] hi;
    logic [wps_pkg::LEN_W-1:0]  len;
    logic [wps_pkg::POS_W-1:0]  start;
    int r;
    for (int k = 0; k < 8; k++) begin
      lo[8*k +: 8] = pick_byte();
      hi[8*k +: 8] = pick_byte();
    end
    r = $urandom_range(99);
    if (r < 70) len = wps_pkg::LEN_W'($urandom_range(1, 6));
    else if (r < 85) len = wps_pkg::LEN_W'($urandom_range(7, 16));
    else if (r < 92) len = '0;
    else len = wps_pkg::LEN_W'($urandom_range(17, 31));
    r = $urandom_range(99);
    if (r < 55) start = wps_pkg::POS_W'($urandom_range(24));
    else if (r < 70) start = '0;
    else if (r < 80) start = '1;
    else if (r < 90) start = 20'hFFFFE;
    else start = wps_pkg::POS_W'($urandom());
    program_search(lo, hi, len, 1'($urandom_range(1)), 1'($urandom_range(1)), start);
  endtask

  // random text, mostly with planted pattern copies in mixed case
  task automatic random_text(output int n);
    text_q_t t;
    int r;
    int at;
    r = $urandom_range(99);
    if (r < 80) n = $urandom_range(1, 24);
    else if (r < 95) n = $urandom_range(25, 60);
    else if (pat_len >= 1 && pat_len <= PATTERN_SLOTS) n = pat_len - 1 + $urandom_range(1);
    else n = 1;
    if (n < 1) n = 1;
    for (int i = 0; i < n; i++) t.insert(t.size(), pick_byte());
    if (pat_len >= 1 && pat_len <= n && pat_len <= PATTERN_SLOTS &&
        $urandom_range(99) < 70) begin
      repeat ($urandom_range(1, 3)) begin
        at = $urandom_range(n - pat_len);
        for (int k = 0; k < pat_len; k++) begin
          t[at+k] = ($urandom_range(99) < 25) ? flip_case(pat_bytes[k]) : pat_bytes[k];
        end
      end
    end
    send_text(t);
  endtask

  initial begin
    int phase_len;
    int n;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: empty pattern never matches
    send_text(from_string("aB"));
    // folded forward search, first match after start
    program_search(64'h6241, '0, 5'd2, 1'b1, 1'b1, '0);
    send_text(from_string("xaBab"));
    // exact-case backward search, last match before start
    program_search(64'h6241, '0, 5'd2, 1'b0, 1'b0, 20'd4);
    send_text(from_string("AbAb"));
    // pattern longer than the text, all-ones pattern words
    program_search('1, '1, 5'd16, 1'b1, 1'b1, '0);
    send_text('{8'h00, 8'hFF, 8'h41});
    // pattern length beyond the window
    program_search('0, '0, 5'd31, 1'b0, 1'b1, '0);
    send_text('{8'h00, 8'h00});
    // forward from the top position leaves nothing after it
    program_search(64'hFF, '1, 5'd1, 1'b1, 1'b1, '1);
    send_text('{8'hFF, 8'hFF});
    // backward from zero leaves nothing before it
    program_search('0, '0, 5'd1, 1'b1, 1'b0, '0);
    send_text('{8'h00, 8'h00});
    // single null byte pattern, forward from zero
    program_search('0, '0, 5'd1, 1'b0, 1'b1, '0);
    send_text('{8'h00, 8'h00});

    // random phases over the idle mixes
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 60; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 60; end
        default: begin tx_idle_pct = 10; rx_stall_pct = 10; end
      endcase
      random_setup();
      phase_len = 0;
      while (phase_len < BYTES_PER_PHASE) begin
        random_text(n);
        phase_len += n;
        // sender holds off until every pending result is out
        if (p == 1 || $urandom_range(9) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.outcomes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== windowed_pattern_search.f =====
sv/wps_pkg.sv
sv/wps_front.sv
sv/wps_queue.sv
sv/wps_back.sv
sv/windowed_pattern_search.sv
sim/tb_top.sv
